/* sv/bis_pkg.sv */
// Shared types and constants for the binary insertion sorter.
package bis_pkg;

   localparam int VALUE_W       = 32;
   localparam int DEPTH_DEFAULT = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic count_one;
   } status_type;

endpackage

/* sv/bis_ctrl.sv */
// Controller: fill phase takes values, drain phase hands out the sorted run.
module bis_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  bis_pkg::status_type status,
   output bis_pkg::cmd_type    cmd
);
   import bis_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      req_xfer;
   logic      rsp_xfer;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      state_in   = state_ff;
      unique case (state_ff)
         ST_FILL: begin
            req_tready = 1'b1;
            if (req_tvalid && req_tlast) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready && status.count_one) begin
               state_in = ST_FILL;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
      req_xfer   = req_tvalid && req_tready;
      rsp_xfer   = rsp_tvalid && rsp_tready;
      cmd.insert = req_xfer;
      cmd.pop    = rsp_xfer;
   end

endmodule

/* sv/bis_datapath.sv */
// Datapath: row of compare-and-shift cells, element count and overflow flag.
module bis_datapath #(
   parameter int DEPTH = bis_pkg::DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bis_pkg::cmd_type     cmd,
   input  bis_pkg::value_type   value,
   output bis_pkg::status_type  status,
   output bis_pkg::value_type   head_value,
   output logic                 overflow
);
   import bis_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   value_type        store_ff [DEPTH];
   value_type        store_in [DEPTH];
   logic [DEPTH-1:0] greater;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic             overflow_ff;
   logic             overflow_in;
   logic             do_insert;

   assign status.full      = (count_ff == CW'(DEPTH));
   assign status.count_one = (count_ff == CW'(1));
   assign do_insert        = cmd.insert && !status.full;
   assign head_value       = store_ff[0];
   assign overflow         = overflow_ff;

   // empty slots act as +infinity, so a value no smaller than every stored one lands at the first free slot
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign greater[i] = (CW'(i) >= count_ff) || (store_ff[i] > value);

      always_comb begin
         store_in[i] = store_ff[i];
         if (do_insert) begin
            if (i > 0 && greater[(i > 0) ? i - 1 : 0]) begin
               store_in[i] = store_ff[(i > 0) ? i - 1 : 0];
            end else if (greater[i]) begin
               store_in[i] = value;
            end
         end else if (cmd.pop && i < DEPTH - 1) begin
            store_in[i] = store_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end

      always_ff @(posedge clock) begin
         store_ff[i] <= store_in[i];
      end
   end

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (do_insert) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.insert && status.full) begin
         overflow_in = 1'b1;
      end else if (cmd.pop && status.count_one) begin
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

endmodule

/* sv/binary_insertion_sorter.sv */
// Top level of the stable binary insertion sorter.
//
//   channel | dir | tdata          | tlast        | tuser
//   req_    | in  | value[31:0]    | last_item    | -
//   rsp_    | out | sorted_value   | last_result  | overflow
//
// One value per cycle in fill: all cells compare against it in parallel.
// After the marked value, one result per cycle, held stable while
// rsp_tready is low; input is held off while the run drains from the head
// cell. Reset clears state, count and overflow; the store needs no reset.
module binary_insertion_sorter #(
   parameter int DEPTH = bis_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [bis_pkg::VALUE_W-1:0]  req_tdata,   // [31:0] value
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [bis_pkg::VALUE_W-1:0]  rsp_tdata,   // [31:0] sorted_value
   output logic                         rsp_tlast,
   output logic                         rsp_tuser    // [0] overflow
);
   import bis_pkg::*;

   cmd_type    cmd;
   status_type status;
   value_type  head_value;

   bis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bis_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .value      (value_type'(req_tdata)),
      .status     (status),
      .head_value (head_value),
      .overflow   (rsp_tuser)
   );

   assign rsp_tdata = head_value;
   assign rsp_tlast = status.count_one;

endmodule

/* sv/bis_checker.sv */
// Port-level checks for the binary insertion sorter, bound to the top level.
module bis_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   a_phase_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a run drains");

   a_drain_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("marked transfer did not start the drain");

   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("drain did not end after last result");

   a_ovf_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && $stable(rsp_tuser))
      else $error("overflow changed within a run");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind binary_insertion_sorter bis_checker u_bis_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

/* test/tb.sv */
// Testbench for binary_insertion_sorter: sorts runs against an in-bench model of the store.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bis_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;

   typedef struct {
      value_type value;
      logic      is_last;
      logic      overflow;
   } sorted_item_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [VALUE_W-1:0]  req_tdata;   // [31:0] value
   logic                req_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [VALUE_W-1:0]  rsp_tdata;   // [31:0] sorted_value
   logic                rsp_tlast;
   logic                rsp_tuser;   // [0] overflow

   binary_insertion_sorter #(.DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   value_type       run_store[$];
   logic            run_overflow;
   sorted_item_type pending_sorted[$];
   int              error_count;
   int              items_sent;
   bit              req_idle_on;
   bit              rsp_idle_on;
   int              rsp_hold;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #200_000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("ERROR @%0t: %s", $time, msg);
   endtask

   // upper-bound insert keeps equal values in arrival order
   function automatic void insert_value(input value_type v, input logic is_last);
      int lo;
      int hi;
      int mid;
      sorted_item_type r;
      if (run_store.size() < DEPTH) begin
         lo = 0;
         hi = run_store.size();
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (run_store[mid] <= v) lo = mid + 1;
            else hi = mid;
         end
         run_store.insert(lo, v);
      end else begin
         run_overflow = 1'b1;
      end
      if (is_last) begin
         foreach (run_store[k]) begin
            r.value    = run_store[k];
            r.is_last  = (k == run_store.size() - 1);
            r.overflow = run_overflow;
            pending_sorted.push_back(r);
         end
         run_store.delete();
         run_overflow = 1'b0;
      end
   endfunction

   task automatic send_value(input value_type v, input logic is_last);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      insert_value(v, is_last);
      items_sent++;
   endtask

   task automatic send_run(input value_type vals[$]);
      foreach (vals[k]) send_value(vals[k], k == vals.size() - 1);
   endtask

   function automatic value_type draw_value(input int style);
      case (style)
         0: draw_value = $urandom;
         1: draw_value = $signed($urandom_range(0, 6)) - 3;
         default: begin
            case ($urandom_range(0, 4))
               0: draw_value = 32'sh8000_0000;
               1: draw_value = 32'sh7fff_ffff;
               2: draw_value = -1;
               3: draw_value = 0;
               default: draw_value = 1;
            endcase
         end
      endcase
   endfunction

   task automatic send_random_run(input int len);
      value_type vals[$];
      int style;
      style = $urandom_range(0, 4);
      repeat (len) vals.push_back(draw_value(style > 2 ? 0 : style));
      if (style == 3) vals.sort();
      if (style == 4) vals.rsort();
      send_run(vals);
   endtask

   // receiver: per-result random gap, plus a long hold when requested
   initial begin : rsp_driver
      int gap;
      gap = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) gap = rsp_idle_on ? $urandom_range(0, 3) : 0;
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else if (gap > 0) begin
            gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      sorted_item_type exp_item;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_sorted.size() == 0) begin
            report_mismatch($sformatf("unexpected result value=%0d", $signed(rsp_tdata)));
         end else begin
            exp_item = pending_sorted.pop_front();
            if (rsp_tdata !== exp_item.value)
               report_mismatch($sformatf("value got %0d exp %0d",
                                         $signed(rsp_tdata), exp_item.value));
            if (rsp_tlast !== exp_item.is_last)
               report_mismatch($sformatf("tlast got %b exp %b value=%0d",
                                         rsp_tlast, exp_item.is_last, exp_item.value));
            if (rsp_tuser !== exp_item.overflow)
               report_mismatch($sformatf("overflow got %b exp %b value=%0d",
                                         rsp_tuser, exp_item.overflow, exp_item.value));
         end
      end
   end

   task automatic test_directed;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_run('{0});
      send_run('{32'sh7fff_ffff, 32'sh8000_0000, -1, 0, 1});
      send_run('{5, 5, -3, 5, -3, 32'sh7fff_ffff, 32'sh7fff_ffff});
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_run('{4, 3, 2, 1, 0, -1, 32'sh8000_0000});
      send_run('{32'sh8000_0000, 32'sh8000_0000});
   endtask

   task automatic test_store_full;
      value_type vals[$];
      for (int k = 0; k < DEPTH; k++) vals.push_back(DEPTH - k);
      send_run(vals);
      vals.push_back(-7);
      send_run(vals);
      send_random_run(DEPTH + 5);
   endtask

   task automatic test_backpressure;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      rsp_hold    = 250;
      send_random_run(DEPTH + 3);
      send_random_run(10);
      send_random_run(3);
   endtask

   task automatic test_random_runs;
      int len;
      while (items_sent < 350) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) len = $urandom_range(DEPTH + 1, DEPTH + 8);
         else len = $urandom_range(1, $urandom_range(1, DEPTH));
         send_random_run(len);
      end
   endtask

   initial begin
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tlast    <= 1'b0;
      run_overflow = 1'b0;
      error_count  = 0;
      items_sent   = 0;
      req_idle_on  = 1'b0;
      rsp_idle_on  = 1'b0;
      rsp_hold     = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_store_full();
      test_backpressure();
      test_random_runs();

      req_tvalid <= 1'b0;
      while (pending_sorted.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
